/* design/rrts_pkg.sv */
// Shared codes and control structures for the round-robin task scheduler.
// Used by the controller, the datapath and the top level; depends on nothing.
package rrts_pkg;

	localparam logic [2:0] FN_CREATE = 3'd0;
	localparam logic [2:0] FN_SCHED = 3'd1;
	localparam logic [2:0] FN_BLOCK = 3'd2;
	localparam logic [2:0] FN_WAKE_ONE = 3'd3;
	localparam logic [2:0] FN_WAKE_ALL = 3'd4;
	localparam logic [2:0] FN_EXIT = 3'd5;

	localparam logic [1:0] RS_OK = 2'd0;
	localparam logic [1:0] RS_NO_SLOT = 2'd1;
	localparam logic [1:0] RS_IGNORED = 2'd2;
	localparam logic [1:0] RS_HALTED = 2'd3;

	localparam logic [1:0] SS_FREE = 2'd0;
	localparam logic [1:0] SS_READY = 2'd1;
	localparam logic [1:0] SS_BLOCKED = 2'd2;
	localparam logic [1:0] SS_RETIRED = 2'd3;

	localparam int IN_BITS = 40;
	localparam int OUT_BITS = 64;

	typedef struct packed {
		logic accept;
		logic dispatch;
		logic scan;
		logic walk;
		logic wake;
		logic finish;
	} rrts_cmd_t;

	typedef struct packed {
		logic       halted;
		logic [2:0] func;
		logic       blk_fail;
		logic       scan_end;
		logic       walk_end;
		logic       wake_end;
		logic       out_free;
	} rrts_stat_t;

endpackage

/* design/rrts_ctrl.sv */
// Controller state machine of the round-robin task scheduler.
// Uses rrts_pkg; drives the datapath through rrts_cmd_t and reads rrts_stat_t.
module rrts_ctrl import rrts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       idle,
	output rrts_cmd_t  cmd,
	input  rrts_stat_t stat
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DISP = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_WALK = 3'd3;
	localparam logic [2:0] S_WAKE = 3'd4;
	localparam logic [2:0] S_FIN = 3'd5;

	logic [2:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = stat.halted ? S_FIN : S_DISP;
				end
			end
			S_DISP: begin
				cmd.dispatch = 1'b1;
				case (stat.func)
					FN_CREATE: state_d = S_SCAN;
					FN_BLOCK: state_d = stat.blk_fail ? S_FIN : S_WALK;
					FN_EXIT: state_d = S_WALK;
					FN_WAKE_ONE, FN_WAKE_ALL: state_d = S_WAKE;
					default: state_d = S_FIN;
				endcase
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_end) state_d = S_FIN;
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (stat.walk_end) state_d = S_FIN;
			end
			S_WAKE: begin
				cmd.wake = 1'b1;
				if (stat.wake_end) state_d = S_FIN;
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign idle = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* design/rrts_dp.sv */
// Datapath of the round-robin task scheduler: slot table, lists, result register.
// Uses rrts_pkg; steered by rrts_ctrl through rrts_cmd_t.
module rrts_dp import rrts_pkg::*; #(
	parameter int MAX_TASKS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rrts_cmd_t             cmd,
	output rrts_stat_t            stat,
	input  logic [2:0]            in_func,
	input  logic [31:0]           in_channel,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_BITS-1:0]   out_data
);

	localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int SW = $clog2(MAX_TASKS + 1);
	localparam logic [SW-1:0] NIL = SW'(MAX_TASKS);
	localparam logic [SW-1:0] LAST = SW'(MAX_TASKS - 1);

	logic [1:0]    sstat_q [MAX_TASKS];
	logic [SW-1:0] ring_q [MAX_TASKS];
	logic [SW-1:0] wlink_q [MAX_TASKS];
	logic [31:0]   chan_q [MAX_TASKS];
	logic [31:0]   ident_q [MAX_TASKS];

	logic [SW-1:0] head_q, run_q, whead_q, ret_q, wtot_q;
	logic [31:0]   idc_q;
	logic          halt_q;

	logic [2:0]    func_q;
	logic [31:0]   ch_q;
	logic [SW-1:0] p_q, wprev_q, n_q;
	logic [1:0]    res_st_q;
	logic [SW-1:0] res_prev_q, res_new_q, res_woken_q;
	logic          out_valid_q;
	logic [OUT_BITS-1:0] out_q;

	logic [SW-1:0] run_nxt, walk_q, hn, wnxt, mr_s, id_sel;
	logic [IW-1:0] run_i, head_i, p_i, wc_i, n_i, mr_i, ret_i, wprev_i;
	logic          head_ok, blk_fail, found, wfail, wactive, match, scan_free;
	logic          do_ready;
	logic [1:0]    out_st;
	logic [3:0]    out_cur, out_prev;
	logic          out_sw;
	logic [31:0]   out_id;

	always_comb begin
		run_i = run_q[IW-1:0];
		head_i = head_q[IW-1:0];
		p_i = p_q[IW-1:0];
		wc_i = p_q[IW-1:0];
		n_i = n_q[IW-1:0];
		ret_i = ret_q[IW-1:0];
		wprev_i = wprev_q[IW-1:0];
		run_nxt = ring_q[run_i];
		head_ok = head_q < NIL;
		hn = ring_q[head_i];
		blk_fail = (sstat_q[run_i] != SS_READY) || (run_nxt == run_q) || !(run_nxt < NIL);
		// Ring predecessor search; p_q walks the ring from the running slot.
		walk_q = ring_q[p_i];
		found = (walk_q < NIL) && (walk_q == run_q);
		wfail = !(walk_q < NIL) || (!found && n_q == LAST);
		// Blocked list walk; p_q doubles as the list cursor.
		wactive = (n_q != NIL) && (p_q < NIL);
		wnxt = wlink_q[wc_i];
		match = chan_q[wc_i] == ch_q;
		scan_free = sstat_q[n_i] == SS_FREE;
		do_ready = (cmd.scan && scan_free) || (cmd.wake && wactive && match);
		mr_s = cmd.scan ? n_q : p_q;
		mr_i = mr_s[IW-1:0];
	end

	always_comb begin
		stat.halted = halt_q;
		stat.func = func_q;
		stat.blk_fail = blk_fail;
		stat.scan_end = scan_free || (n_q == LAST);
		stat.walk_end = wfail || found;
		stat.wake_end = !wactive || (match && func_q == FN_WAKE_ONE);
		stat.out_free = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TASKS; i++) begin
				sstat_q[i] <= (i < 2) ? SS_READY : SS_FREE;
				ring_q[i] <= (i == 0) ? SW'(1) : '0;
				wlink_q[i] <= NIL;
				chan_q[i] <= '0;
				ident_q[i] <= (i == 1) ? 32'd1 : 32'd0;
			end
			head_q <= '0;
			run_q <= '0;
			whead_q <= NIL;
			ret_q <= NIL;
			idc_q <= 32'd2;
			wtot_q <= '0;
			halt_q <= 1'b0;
		end else begin
			if (cmd.dispatch && func_q == FN_SCHED) begin
				if (ret_q < NIL) sstat_q[ret_i] <= SS_FREE;
				ret_q <= NIL;
				if (run_nxt != run_q && run_nxt < NIL) run_q <= run_nxt;
			end
			if (cmd.scan && scan_free) begin
				ident_q[n_i] <= idc_q;
				idc_q <= idc_q + 32'd1;
			end
			if (cmd.walk && func_q == FN_BLOCK && !wfail && found) begin
				ring_q[p_i] <= run_nxt;
				if (head_q == run_q) head_q <= run_nxt;
				ring_q[run_i] <= '0;
				wlink_q[run_i] <= whead_q;
				chan_q[run_i] <= ch_q;
				sstat_q[run_i] <= SS_BLOCKED;
				whead_q <= run_q;
				wtot_q <= wtot_q + SW'(1);
				run_q <= run_nxt;
			end
			if (cmd.walk && func_q == FN_EXIT) begin
				if (wfail || p_q == run_q && found) begin
					halt_q <= 1'b1;
				end else if (found) begin
					if (ret_q < NIL) sstat_q[ret_i] <= SS_FREE;
					ring_q[p_i] <= run_nxt;
					if (head_q == run_q) head_q <= run_nxt;
					sstat_q[run_i] <= SS_RETIRED;
					ret_q <= run_q;
					run_q <= run_nxt;
				end
			end
			if (cmd.wake && wactive && match) begin
				if (wprev_q < NIL) wlink_q[wprev_i] <= wnxt;
				else whead_q <= wnxt;
				if (wtot_q != '0) wtot_q <= wtot_q - SW'(1);
			end
			// Moving a slot onto the ring right after its head.
			if (do_ready) begin
				sstat_q[mr_i] <= SS_READY;
				chan_q[mr_i] <= '0;
				wlink_q[mr_i] <= NIL;
				if (!head_ok) begin
					ring_q[mr_i] <= mr_s;
					head_q <= mr_s;
				end else begin
					ring_q[mr_i] <= hn;
					ring_q[head_i] <= mr_s;
				end
			end
		end
	end

	// Per-item working registers; they need no reset.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q <= in_func;
			ch_q <= in_channel;
			res_st_q <= halt_q ? RS_HALTED : RS_OK;
			res_prev_q <= halt_q ? '0 : run_q;
			res_new_q <= '0;
			res_woken_q <= '0;
		end
		if (cmd.dispatch) begin
			n_q <= '0;
			p_q <= (func_q == FN_WAKE_ONE || func_q == FN_WAKE_ALL) ? whead_q : run_q;
			wprev_q <= NIL;
			case (func_q)
				FN_CREATE, FN_EXIT, FN_WAKE_ONE, FN_WAKE_ALL: ;
				FN_SCHED: if (run_nxt == run_q || !(run_nxt < NIL)) res_st_q <= RS_IGNORED;
				FN_BLOCK: if (blk_fail) res_st_q <= RS_IGNORED;
				default: res_st_q <= RS_IGNORED;
			endcase
		end
		if (cmd.scan) begin
			if (scan_free) res_new_q <= n_q;
			else if (n_q == LAST) res_st_q <= RS_NO_SLOT;
			n_q <= n_q + SW'(1);
		end
		if (cmd.walk) begin
			if (wfail || (func_q == FN_EXIT && found && p_q == run_q))
				res_st_q <= (func_q == FN_EXIT) ? RS_HALTED : RS_IGNORED;
			p_q <= walk_q;
			n_q <= n_q + SW'(1);
		end
		if (cmd.wake && wactive) begin
			if (match) res_woken_q <= res_woken_q + SW'(1);
			else wprev_q <= p_q;
			p_q <= wnxt;
			n_q <= n_q + SW'(1);
		end
	end

	always_comb begin
		id_sel = (func_q == FN_CREATE && res_st_q == RS_OK) ? res_new_q : run_q;
		out_st = res_st_q;
		out_prev = 4'(res_prev_q);
		if (halt_q) begin
			out_cur = '0;
			out_sw = 1'b0;
			out_id = '0;
		end else begin
			out_cur = 4'(run_q);
			out_sw = run_q != res_prev_q;
			out_id = ident_q[id_sel[IW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q <= {7'd0, 5'(wtot_q), 5'(res_woken_q), 4'(res_new_q), out_id, out_sw,
				out_prev, out_cur, out_st};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

/* design/round_robin_task_scheduler_core.sv */
// Top level of the round-robin task scheduler: controller plus datapath.
// Uses rrts_pkg, rrts_ctrl and rrts_dp.
//
// The block takes one scheduler call per word on the slave stream (s_*) and
// returns one result word per call on the master stream (m_*). A call is
// create, schedule, block current, wake one, wake all or exit current; the
// result tells the status, the running slot before and after, whether a
// switch happened, a task id, the slot of a created task, the number of
// tasks woken and the blocked list length.
// Calls are handled one at a time. Schedule, unknown and at once refused block
// calls go straight to the result (so do all calls once halted), create scans
// for a free slot, block and exit walk the ring for the predecessor, and wakes
// walk the blocked list; every walk steps one entry per cycle.
// s_tready is high while the controller is idle, so a new word is taken even
// while a finished result still waits in the output register; that call then
// waits at its last step until m_tready frees the register.
// After reset slot 0 runs the main task (id 0), slot 1 holds the idle task
// (id 1), and no task is blocked. After the last task exits the block stays
// halted and answers every call with the halted status until reset.
module round_robin_task_scheduler_core import rrts_pkg::*; #(
	parameter int MAX_TASKS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// func [2:0], channel [34:3], zero pad [39:35]
	input  logic [IN_BITS-1:0]  s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// status [1:0], current_slot [5:2], prev_slot [9:6], switched [10],
	// task_id [42:11], new_slot [46:43], woken_count [51:47],
	// blocked_count [56:52], zero pad [63:57]
	output logic [OUT_BITS-1:0] m_tdata
);

	rrts_cmd_t  cmd;
	rrts_stat_t stat;
	logic       idle;

	rrts_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.idle(idle),
		.cmd(cmd),
		.stat(stat)
	);

	rrts_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.stat(stat),
		.in_func(s_tdata[2:0]),
		.in_channel(s_tdata[34:3]),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data(m_tdata)
	);

	assign s_tready = idle;

	// A call keeps the controller busy, so no second word is taken while it is in progress.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second word accepted while a call is in progress");

	// A halted answer carries no running slot, switch or id.
	a_halted_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == RS_HALTED |->
		m_tdata[5:2] == 4'd0 && m_tdata[10] == 1'b0 && m_tdata[42:11] == 32'd0)
		else $error("halted result carries task data");

	// Only a successful call may switch tasks.
	a_switch_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[10] |-> m_tdata[1:0] == RS_OK)
		else $error("task switch reported with a failing status");

	// Only wake calls report woken tasks, and a result word is produced only
	// while the controller is busy or just finished.
	a_woken_only_wake: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish && stat.func != FN_WAKE_ONE && stat.func != FN_WAKE_ALL |=>
		m_tdata[51:47] == 5'd0)
		else $error("woken tasks reported by a call that is no wake");

endmodule

/* tb/sv/round_robin_task_scheduler_core_tb.sv */
// Testbench for the round-robin task scheduler core: random and directed calls,
// checked against an in-bench scheduler model. Depends on rrts_pkg and the core.
module round_robin_task_scheduler_core_tb import rrts_pkg::*;;

	localparam int NT = 16;
	localparam logic [4:0] NIL = 5'(NT);

	// One result word, unpacked.
	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  cur_slot;
		logic [3:0]  prv_slot;
		logic        switched;
		logic [31:0] task_id;
		logic [3:0]  new_slot;
		logic [4:0]  woken;
		logic [4:0]  blocked;
	} sched_res_t;

	// Scheduler model plus the queue of results it predicts.
	class sched_board;
		logic [1:0]  st[NT];
		logic [4:0]  rlink[NT];
		logic [4:0]  wlink[NT];
		logic [31:0] chan[NT];
		logic [31:0] ident[NT];
		logic [4:0]  rhead, run, whead, retired, wtotal;
		logic [31:0] next_id;
		bit          halted;
		sched_res_t  pending[$];
		int          errors;

		function new();
			for (int i = 0; i < NT; i++) begin
				st[i] = SS_FREE; rlink[i] = 0; wlink[i] = NIL; chan[i] = 0; ident[i] = 0;
			end
			st[0] = SS_READY; st[1] = SS_READY; rlink[0] = 1; ident[1] = 1;
			rhead = 0; run = 0; whead = NIL; retired = NIL; next_id = 2; wtotal = 0;
			halted = 0; errors = 0;
		endfunction

		function int ready_count();
			int n;
			n = 0;
			for (int i = 0; i < NT; i++) if (st[i] == SS_READY) n++;
			return n;
		endfunction

		function void reap();
			if (retired < NIL) st[retired] = SS_FREE;
			retired = NIL;
		endfunction

		function void ready_up(logic [4:0] s);
			st[s] = SS_READY; chan[s] = 0; wlink[s] = NIL;
			if (rhead >= NIL) begin
				rlink[s] = s; rhead = s;
			end else begin
				rlink[s] = rlink[rhead]; rlink[rhead] = s;
			end
		endfunction

		function logic [4:0] ring_pred(logic [4:0] s);
			logic [4:0] p, q;
			p = s;
			for (int n = 0; n < NT; n++) begin
				q = rlink[p];
				if (q >= NIL) return NIL;
				if (q == s) return p;
				p = q;
			end
			return NIL;
		endfunction

		function logic [4:0] wake_up(logic [31:0] ch, bit one);
			logic [4:0] cnt, prv, cur, nxt;
			cnt = 0; prv = NIL; cur = whead;
			for (int n = 0; n < NT && cur < NIL; n++) begin
				nxt = wlink[cur];
				if (chan[cur] == ch) begin
					if (prv < NIL) wlink[prv] = nxt; else whead = nxt;
					if (wtotal > 0) wtotal--;
					ready_up(cur);
					cnt++;
					if (one) break;
				end else prv = cur;
				cur = nxt;
			end
			return cnt;
		endfunction

		// Notes an accepted call and queues its expected result.
		function void note_call(logic [2:0] fn, logic [31:0] ch);
			sched_res_t r;
			logic [4:0] cur, nxt, p;
			int i;
			r = '0;
			if (halted) r.status = RS_HALTED;
			else begin
				cur = run;
				r.prv_slot = cur[3:0];
				case (fn)
					FN_CREATE: begin
						for (i = 0; i < NT; i++) if (st[i] == SS_FREE) break;
						if (i >= NT) r.status = RS_NO_SLOT;
						else begin
							ident[i] = next_id; next_id++;
							ready_up(5'(i)); r.new_slot = 4'(i);
						end
					end
					FN_SCHED: begin
						reap();
						nxt = rlink[cur];
						if (nxt == cur || nxt >= NIL) r.status = RS_IGNORED; else run = nxt;
					end
					FN_BLOCK: begin
						nxt = rlink[cur];
						if (st[cur] != SS_READY || nxt == cur || nxt >= NIL) r.status = RS_IGNORED;
						else begin
							p = ring_pred(cur);
							if (p >= NIL) r.status = RS_IGNORED;
							else begin
								rlink[p] = nxt;
								if (rhead == cur) rhead = nxt;
								rlink[cur] = 0; wlink[cur] = whead; chan[cur] = ch;
								st[cur] = SS_BLOCKED; whead = cur; wtotal++; run = nxt;
							end
						end
					end
					FN_WAKE_ONE, FN_WAKE_ALL: r.woken = wake_up(ch, fn == FN_WAKE_ONE);
					FN_EXIT: begin
						p = ring_pred(cur);
						if (p >= NIL || p == cur) begin
							halted = 1; r.status = RS_HALTED;
						end else begin
							reap();
							nxt = rlink[cur]; rlink[p] = nxt;
							if (rhead == cur) rhead = nxt;
							st[cur] = SS_RETIRED; retired = cur; run = nxt;
						end
					end
					default: r.status = RS_IGNORED;
				endcase
				if (halted) r.prv_slot = cur[3:0];
				else begin
					r.cur_slot = run[3:0];
					r.switched = run != cur;
					r.task_id = (fn == FN_CREATE && r.status == RS_OK) ? ident[r.new_slot]
						: ident[run];
				end
			end
			r.blocked = wtotal;
			pending.push_back(r);
		endfunction

		// Compares one result word with the oldest expectation.
		function void check_result(logic [OUT_BITS-1:0] word);
			sched_res_t got, exp_r;
			got = {word[1:0], word[5:2], word[9:6], word[10], word[42:11], word[46:43],
				word[51:47], word[56:52]};
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, word);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got !== exp_r || word[63:57] !== '0) begin
				$display("%0t: result mismatch, expected %h, actual %h", $time, exp_r, got);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0;
	logic s_tvalid = 0, m_tready = 0;
	logic [IN_BITS-1:0] s_tdata = '0;
	logic s_tready, m_tvalid;
	logic [OUT_BITS-1:0] m_tdata;
	bit hold_off = 0;
	int sent = 0;

	sched_board board = new();

	round_robin_task_scheduler_core #(.MAX_TASKS(NT)) dut (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	function automatic int gap_len();
		return ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(2);
	endfunction

	// Offers one call and waits until the block takes it; tvalid drops only
	// when a gap follows.
	task automatic send_call(logic [2:0] fn, logic [31:0] ch);
		int g;
		g = ($urandom_range(3) == 0) ? 0 : gap_len();
		if (g > 0) begin
			s_tvalid <= 0;
			repeat (g) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {5'b0, ch, fn};
		do @(posedge clk); while (!s_tready);
		board.note_call(fn, ch);
		sent++;
	endtask

	// Receiver: random stalls, and one long hold-off counted here once the
	// sender asks for it.
	initial begin
		int hold_left;
		bit held;
		hold_left = 0;
		held = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) board.check_result(m_tdata);
			if (hold_off && !held) begin
				held = 1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 0;
			end else m_tready <= ($urandom_range(4) != 0);
		end
	end

	// Mostly valid-ish traffic from one of two patterns.
	function automatic logic [2:0] pick_func(int mode);
		int r;
		r = $urandom_range(99);
		if (r < 2) return 3'($urandom_range(6, 7));
		if (board.ready_count() <= 2 && r < 60) return (r < 40) ? FN_CREATE : FN_WAKE_ALL;
		if (r < 22) return FN_CREATE;
		if (r < 42) return FN_SCHED;
		if (r < 60) return FN_BLOCK;
		if (r < 74) return FN_WAKE_ONE;
		if (r < 84) return FN_WAKE_ALL;
		return (mode == 0) ? FN_SCHED : FN_EXIT;
	endfunction

	initial begin
		logic [31:0] chs[4];
		int wait_cycles;
		chs = '{32'h0, 32'hFFFF_FFFF, 32'h5555_AAAA, 32'hAAAA_5555};
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed: schedule, block, sole-ready block, wakes, bad codes, fill table.
		send_call(FN_SCHED, 0);
		send_call(FN_BLOCK, 32'hFFFF_FFFF);
		send_call(FN_SCHED, 0);
		send_call(FN_BLOCK, 0);
		send_call(FN_WAKE_ONE, 32'h1234_5678);
		send_call(FN_WAKE_ALL, 32'hFFFF_FFFF);
		send_call(FN_WAKE_ONE, 0);
		send_call(3'd6, 32'hFFFF_FFFF);
		send_call(3'd7, 0);
		// Long receiver hold-off while the table fills and overflows.
		hold_off = 1;
		for (int i = 0; i < 16; i++) send_call(FN_CREATE, 0);
		hold_off = 0;
		send_call(FN_EXIT, 0);
		send_call(FN_CREATE, 0);
		send_call(FN_SCHED, 0);
		// Random phase: several runs each ending in a halt is impossible (no reset),
		// so most runs avoid draining the ring until the very end.
		while (sent < 1000) begin
			logic [2:0] fn;
			fn = pick_func(sent % 7 == 0 ? 1 : 0);
			if (fn == FN_EXIT && board.ready_count() <= 2) fn = FN_SCHED;
			send_call(fn, ($urandom_range(7) == 0) ? $urandom() : chs[$urandom_range(3)]);
		end
		// Drain the ring until the block halts, then poke it while halted.
		while (!board.halted) begin
			if (board.wtotal != 0) send_call(FN_WAKE_ALL, board.chan[board.whead]);
			else send_call(FN_EXIT, $urandom());
		end
		send_call(FN_CREATE, 0);
		send_call(FN_WAKE_ALL, 0);
		s_tvalid <= 0;
		wait_cycles = 0;
		while (board.pending.size() != 0 && wait_cycles < 100000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (40) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end

	initial begin
		#40000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
